/* hdl/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/wia128_pkg.sv */
// package for the 128-bit integer alu: widths, opcodes and sequencer states
package wia128_pkg;

   localparam int DATA_BITS    = 128;
   localparam int HALF_BITS    = DATA_BITS / 2;
   localparam int OPCODE_BITS  = 4;
   localparam int COUNT_BITS   = $clog2(DATA_BITS);
   localparam int OPERAND_BITS = 128;
   // shift amounts at or above this give zero
   localparam int SHIFT_LIMIT  = (OPERAND_BITS > DATA_BITS) ? DATA_BITS : OPERAND_BITS;
   // operand fields packed into the request payload
   localparam int REQ_DATA_BITS = 4 * HALF_BITS;
   // result fields plus compare flag, padded to whole bytes
   localparam int RSP_FIELD_BITS = DATA_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_AND = 4'd5,
      OP_OR  = 4'd6,
      OP_XOR = 4'd7,
      OP_NOT = 4'd8,
      OP_SHL = 4'd9,
      OP_SHR = 4'd10,
      OP_LT  = 4'd11,
      OP_LE  = 4'd12,
      OP_GT  = 4'd13,
      OP_GE  = 4'd14,
      OP_EQ  = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_ITER   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

endpackage

/* hdl/wide_integer_alu_128_unit.sv */
// 128-bit unsigned integer alu with a shared adder under a small sequencer
// add, sub, logic, shift and compare go from the request regs through the finish state into the rsp regs
// mul, div and mod run 128 radix-2 steps through the one 129-bit adder before the finish state
// divide by zero skips the steps and goes straight to the finish state
// one item in flight: a new request is taken only in idle, once the last result is in the rsp regs
// reset (synchronous, active high) returns the sequencer to idle and drops rsp_tvalid
`include "assert_macros.svh"

module wide_integer_alu_128_unit #(
   parameter int OPERAND_BITS = wia128_pkg::OPERAND_BITS
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // tdata fields from bit 0 up: x_low, x_high, y_low, y_high
   input  logic [wia128_pkg::REQ_DATA_BITS-1:0]      req_tdata,
   // tuser fields from bit 0 up: opcode
   input  logic [wia128_pkg::OPCODE_BITS-1:0]        req_tuser,
   // result channel
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // tdata fields from bit 0 up: result_low, result_high, compare_true, zero pad
   output logic [wia128_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);

   localparam int DB = wia128_pkg::DATA_BITS;
   localparam int HB = wia128_pkg::HALF_BITS;
   localparam logic [wia128_pkg::COUNT_BITS-1:0] LAST_STEP =
      wia128_pkg::COUNT_BITS'(DB - 1);
   // shift amounts at or above this give zero; anything above the word width acts as it
   localparam logic [HB-1:0] SHIFT_LIMIT_W = HB'((OPERAND_BITS > DB) ? DB : OPERAND_BITS);
   localparam int PAD_BITS = wia128_pkg::RSP_DATA_BITS - wia128_pkg::RSP_FIELD_BITS;

   // sequencer and control
   wia128_pkg::state_type  state_ff, state_in;
   wia128_pkg::opcode_type op_ff, op_in;
   logic [wia128_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   // datapath: a holds x, multiplicand or dividend/quotient; b holds y or multiplier
   logic [DB-1:0] a_ff, a_in;
   logic [DB-1:0] b_ff, b_in;
   logic [DB-1:0] acc_ff, acc_in;     // product or partial remainder
   logic [wia128_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // shared adder
   logic [DB-1:0] add_a, add_b;
   logic          add_sub;
   logic [DB:0]   add_sum;

   logic          req_xfer;
   logic          out_free;
   logic [DB-1:0] x_w, y_w;
   logic [DB-1:0] rem_shift;
   logic          take;
   logic          y_zero;
   logic          is_long;
   logic          shift_ok;
   logic [wia128_pkg::COUNT_BITS-1:0] shamt;
   logic [DB-1:0] res_w;
   logic          flag_w;
   logic          lt_w, eq_w;

   assign req_tready = (state_ff == wia128_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign x_w = req_tdata[2*HB-1:0];
   assign y_w = req_tdata[4*HB-1:2*HB];

   // divide step: shift the next dividend bit into the remainder
   assign rem_shift = {acc_ff[DB-2:0], a_ff[DB-1]};

   // shared adder operand selection
   always_comb begin
      add_a   = a_ff;
      add_b   = b_ff;
      add_sub = 1'b1;
      if (state_ff == wia128_pkg::ST_ITER) begin
         if (op_ff == wia128_pkg::OP_MUL) begin
            add_a   = acc_ff;
            add_b   = a_ff;
            add_sub = 1'b0;
         end else begin
            add_a   = rem_shift;
            add_b   = b_ff;
            add_sub = 1'b1;
         end
      end else if (op_ff == wia128_pkg::OP_ADD) begin
         add_sub = 1'b0;
      end
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {DB{add_sub}}} + (DB + 1)'(add_sub);

   // restoring divide keeps the difference when the shifted-out remainder bit is set or on carry-out (no borrow)
   assign take = acc_ff[DB-1] || add_sum[DB];

   // compares from the subtract: carry-out means x >= y
   assign lt_w = !add_sum[DB];
   assign eq_w = (a_ff == b_ff);

   assign shift_ok = (b_ff[DB-1:HB] == '0) && (b_ff[HB-1:0] < SHIFT_LIMIT_W);
   assign shamt    = b_ff[wia128_pkg::COUNT_BITS-1:0];

   // results of the short operations and the outputs of the long operations
   always_comb begin
      res_w  = '0;
      flag_w = 1'b0;
      case (op_ff)
         wia128_pkg::OP_ADD: res_w = add_sum[DB-1:0];
         wia128_pkg::OP_SUB: res_w = add_sum[DB-1:0];
         wia128_pkg::OP_MUL: res_w = acc_ff;
         wia128_pkg::OP_DIV: res_w = a_ff;
         wia128_pkg::OP_MOD: res_w = acc_ff;
         wia128_pkg::OP_AND: res_w = a_ff & b_ff;
         wia128_pkg::OP_OR:  res_w = a_ff | b_ff;
         wia128_pkg::OP_XOR: res_w = a_ff ^ b_ff;
         wia128_pkg::OP_NOT: res_w = ~a_ff;
         wia128_pkg::OP_SHL: res_w = shift_ok ? (a_ff << shamt) : '0;
         wia128_pkg::OP_SHR: res_w = shift_ok ? (a_ff >> shamt) : '0;
         wia128_pkg::OP_LT:  flag_w = lt_w;
         wia128_pkg::OP_LE:  flag_w = lt_w || eq_w;
         wia128_pkg::OP_GT:  flag_w = !(lt_w || eq_w);
         wia128_pkg::OP_GE:  flag_w = !lt_w;
         wia128_pkg::OP_EQ:  flag_w = eq_w;
         default:            flag_w = 1'b0;
      endcase
   end

   assign y_zero  = (y_w == '0);
   assign is_long = req_tuser inside {wia128_pkg::OP_MUL, wia128_pkg::OP_DIV,
                                      wia128_pkg::OP_MOD};

   // sequencer next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         wia128_pkg::ST_IDLE: begin
            if (req_xfer) begin
               op_in    = wia128_pkg::opcode_type'(req_tuser);
               count_in = '0;
               a_in     = x_w;
               b_in     = y_w;
               acc_in   = '0;
               if (is_long && req_tuser != wia128_pkg::OP_MUL && y_zero) begin
                  // divide by zero: quotient 0, remainder x
                  a_in     = '0;
                  acc_in   = x_w;
                  state_in = wia128_pkg::ST_FINISH;
               end else if (is_long) begin
                  state_in = wia128_pkg::ST_ITER;
               end else begin
                  state_in = wia128_pkg::ST_FINISH;
               end
            end
         end
         wia128_pkg::ST_ITER: begin
            if (op_ff == wia128_pkg::OP_MUL) begin
               // shift-add: add multiplicand on a set multiplier bit
               acc_in = b_ff[0] ? add_sum[DB-1:0] : acc_ff;
               a_in   = a_ff << 1;
               b_in   = b_ff >> 1;
            end else begin
               // restoring divide: quotient bits shift in behind the dividend
               acc_in = take ? add_sum[DB-1:0] : rem_shift;
               a_in   = {a_ff[DB-2:0], take};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = wia128_pkg::ST_FINISH;
            end
         end
         wia128_pkg::ST_FINISH: begin
            // hand the result to the rsp regs once they are free
            if (out_free) begin
               rsp_data_in  = {{PAD_BITS{1'b0}}, flag_w, res_w};
               rsp_valid_in = 1'b1;
               state_in     = wia128_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wia128_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wia128_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // step counter advances by one on every divide or multiply step
   `ASSERT_CLK(a_count_step, clock, reset, (state_ff == wia128_pkg::ST_ITER) |=> (count_ff == $past(count_ff) + 1'b1), "step counter did not advance")

   // an accepted request always leaves idle
   `ASSERT_CLK(a_req_leaves_idle, clock, reset, req_xfer |=> (state_ff != wia128_pkg::ST_IDLE), "request transfer did not start work")

   // a set compare flag comes with a zero result value
   `ASSERT_CLK(a_flag_zero_value, clock, reset, (rsp_tvalid && rsp_tdata[DB]) |-> (rsp_tdata[DB-1:0] == '0), "compare result carries nonzero value")

   // the final step always hands over to the finish state
   `ASSERT_CLK(a_last_step, clock, reset, (state_ff == wia128_pkg::ST_ITER && count_ff == LAST_STEP) |=> (state_ff == wia128_pkg::ST_FINISH), "last step did not finish")

endmodule

/* bench/tb_wide_integer_alu_128_unit.sv */
// testbench for the 128-bit integer alu: directed corners and random stream traffic checked against a predictor
`timescale 1ns / 1ps

module tb_wide_integer_alu_128_unit;

   // cap on simulated cycles for the whole run, after which the watchdog reports failure
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned RANDOM_ITEMS = 800;
   // how long to keep watching for stray results after the last one is checked
   localparam int unsigned DRAIN_CYCLES = 150;
   // shift amounts at or above this give zero; anything above 128 acts as 128
   localparam int unsigned SHIFT_CAP =
      (wia128_pkg::OPERAND_BITS > wia128_pkg::DATA_BITS) ? wia128_pkg::DATA_BITS
                                                         : wia128_pkg::OPERAND_BITS;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // x_low, x_high, y_low, y_high from bit 0 up
   logic [wia128_pkg::REQ_DATA_BITS-1:0] req_tdata;
   // opcode
   logic [wia128_pkg::OPCODE_BITS-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   // result_low, result_high, compare_true, zero pad from bit 0 up
   logic [wia128_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   int unsigned cycle_count;

   typedef struct {
      wia128_pkg::opcode_type op;
      logic [127:0]           value;
      logic                   holds;
   } alu_outcome_type;

   // keeps the outcomes of accepted requests in order and compares result transfers
   class alu_result_checker;
      alu_outcome_type pending_outcomes[$];
      int unsigned     failures;

      function new();
         failures = 0;
      endfunction

      // what the alu must answer for one request
      function alu_outcome_type predict_outcome(wia128_pkg::opcode_type op,
                                                logic [127:0] x, logic [127:0] y);
         alu_outcome_type o;
         o.op    = op;
         o.value = '0;
         o.holds = 1'b0;
         case (op)
            wia128_pkg::OP_ADD: o.value = x + y;
            wia128_pkg::OP_SUB: o.value = x - y;
            wia128_pkg::OP_MUL: o.value = x * y;
            // divide by zero: quotient 0, remainder is x
            wia128_pkg::OP_DIV: o.value = (y == '0) ? '0 : x / y;
            wia128_pkg::OP_MOD: o.value = (y == '0) ? x : x % y;
            wia128_pkg::OP_AND: o.value = x & y;
            wia128_pkg::OP_OR:  o.value = x | y;
            wia128_pkg::OP_XOR: o.value = x ^ y;
            wia128_pkg::OP_NOT: o.value = ~x;
            // oversized amount gives zero, otherwise the low 7 bits count
            wia128_pkg::OP_SHL: if (y < SHIFT_CAP) o.value = x << y[6:0];
            wia128_pkg::OP_SHR: if (y < SHIFT_CAP) o.value = x >> y[6:0];
            wia128_pkg::OP_LT:  o.holds = (x < y);
            wia128_pkg::OP_LE:  o.holds = (x <= y);
            wia128_pkg::OP_GT:  o.holds = (x > y);
            wia128_pkg::OP_GE:  o.holds = (x >= y);
            default: o.holds = (x == y);
         endcase
         return o;
      endfunction

      function void note_request(wia128_pkg::opcode_type op, logic [127:0] x,
                                 logic [127:0] y);
         pending_outcomes.push_back(predict_outcome(op, x, y));
      endfunction

      function void check_result(logic [63:0] low, logic [63:0] high, logic flag);
         alu_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            $error("result transfer with no request pending: %h %h %b", high, low, flag);
            failures++;
            return;
         end
         o = pending_outcomes.pop_front();
         if (low !== o.value[63:0]) begin
            $error("%s result_low: expected %h, got %h", o.op.name(), o.value[63:0], low);
            failures++;
         end
         if (high !== o.value[127:64]) begin
            $error("%s result_high: expected %h, got %h", o.op.name(), o.value[127:64],
                   high);
            failures++;
         end
         if (flag !== o.holds) begin
            $error("%s compare_true: expected %b, got %b", o.op.name(), o.holds, flag);
            failures++;
         end
      endfunction
   endclass

   alu_result_checker scoreboard = new();

   wide_integer_alu_128_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle cycles before the next transfer; now and then a run of back-to-back items
   function automatic int unsigned draw_gap(ref int unsigned burst_left);
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 25);
      return $urandom_range(0, 14);
   endfunction

   // full-range values mixed with the corners of a 128-bit word
   function automatic logic [127:0] random_operand();
      logic [127:0] v;
      v = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = 128'd1;
         2: v = '1;
         3: v = {1'b1, 127'd0};
         4: v = {64'd0, {64{1'b1}}};
         5: v = {64'd1, 64'd0};
         6: v = v >> $urandom_range(1, 127);
         7: v = 128'($urandom_range(0, 255));
         default: ;
      endcase
      return v;
   endfunction

   int unsigned send_burst_left;

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_request(wia128_pkg::opcode_type op, logic [127:0] x,
                               logic [127:0] y);
      int unsigned gap;
      gap = draw_gap(send_burst_left);
      // valid stays high across back-to-back items, never dropped and raised in one step
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {y[127:64], y[63:0], x[127:64], x[63:0]};
      do @(posedge clock); while (req_tready !== 1'b1);
      scoreboard.note_request(op, x, y);
      @(negedge clock);
   endtask

   // result side: random stalls, every transfer goes to the checker
   initial begin : result_sink
      int unsigned gap;
      int unsigned burst_left;
      burst_left = 0;
      rsp_tready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(burst_left);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         scoreboard.check_result(rsp_tdata[63:0], rsp_tdata[127:64], rsp_tdata[128]);
         @(negedge clock);
      end
   end

   // hang guard
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      logic [127:0] all_ones;
      logic [127:0] x;
      logic [127:0] y;
      wia128_pkg::opcode_type op;
      all_ones = '1;
      send_burst_left = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= wia128_pkg::OP_ADD;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners
      // wraps to zero
      send_request(wia128_pkg::OP_ADD, all_ones, 128'd1);
      // carry into high half
      send_request(wia128_pkg::OP_ADD, {64'd0, {64{1'b1}}}, 128'd1);
      // wraps to all ones
      send_request(wia128_pkg::OP_SUB, 128'd0, 128'd1);
      // borrow from high half
      send_request(wia128_pkg::OP_SUB, {64'd1, 64'd0}, 128'd1);
      send_request(wia128_pkg::OP_MUL, all_ones, all_ones);
      // product exactly 2^128
      send_request(wia128_pkg::OP_MUL, {64'd1, 64'd0}, {64'd1, 64'd0});
      send_request(wia128_pkg::OP_DIV, all_ones, 128'd3);
      // divide by zero
      send_request(wia128_pkg::OP_DIV, all_ones, 128'd0);
      // remainder is x
      send_request(wia128_pkg::OP_MOD, all_ones, 128'd0);
      // divisor above dividend
      send_request(wia128_pkg::OP_DIV, 128'd5, all_ones);
      send_request(wia128_pkg::OP_MOD, {1'b1, 127'd0}, all_ones);
      send_request(wia128_pkg::OP_AND, all_ones, {64{2'b01}});
      send_request(wia128_pkg::OP_OR, {64{2'b10}}, {64{2'b01}});
      send_request(wia128_pkg::OP_XOR, all_ones, {64{2'b10}});
      // y ignored
      send_request(wia128_pkg::OP_NOT, all_ones, {$urandom, $urandom, $urandom, $urandom});
      send_request(wia128_pkg::OP_SHL, all_ones, 128'd0);
      send_request(wia128_pkg::OP_SHL, all_ones, 128'd127);
      // at the cap gives zero
      send_request(wia128_pkg::OP_SHL, all_ones, 128'd128);
      send_request(wia128_pkg::OP_SHR, all_ones, 128'd64);
      // upper half of amount set
      send_request(wia128_pkg::OP_SHR, all_ones, {64'd1, 64'd3});
      send_request(wia128_pkg::OP_LT, all_ones, all_ones);
      send_request(wia128_pkg::OP_LE, all_ones, all_ones);
      send_request(wia128_pkg::OP_GT, {64'd1, 64'd0}, {64'd0, {64{1'b1}}});
      send_request(wia128_pkg::OP_GE, 128'd0, all_ones);
      send_request(wia128_pkg::OP_EQ, {1'b1, 127'd0}, {1'b1, 127'd0});

      // random traffic, operands shaped per operation
      repeat (RANDOM_ITEMS) begin
         op = wia128_pkg::opcode_type'($urandom_range(0, 15));
         x  = random_operand();
         y  = random_operand();
         case (op)
            wia128_pkg::OP_DIV, wia128_pkg::OP_MOD: begin
               // mostly divisors narrower than the full word
               if ($urandom_range(0, 1) != 0) y = y >> $urandom_range(1, 127);
            end
            wia128_pkg::OP_SHL, wia128_pkg::OP_SHR: begin
               case ($urandom_range(0, 7))
                  0, 1, 2, 3, 4: y = 128'($urandom_range(0, 127));
                  5: y = 128'($urandom_range(128, 300));
                  6: y = {64'($urandom) | 64'd1, 64'($urandom_range(0, 127))};
                  default: ;
               endcase
            end
            wia128_pkg::OP_LT, wia128_pkg::OP_LE, wia128_pkg::OP_GT,
            wia128_pkg::OP_GE, wia128_pkg::OP_EQ: begin
               // neighbors and equal operands hit the compare boundaries
               case ($urandom_range(0, 3))
                  0: y = x;
                  1: y = x + 128'd1;
                  2: y = x - 128'd1;
                  default: ;
               endcase
            end
            default: ;
         endcase
         send_request(op, x, y);
      end
      req_tvalid <= 1'b0;

      while (scoreboard.pending_outcomes.size() != 0) @(posedge clock);
      // any stray result would show up in this window
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
